// ----- rtl/core/hbs_pkg.sv -----
package hbs_pkg;

    // Default depth of the 2^f interpolation table
    localparam int DEF_EXP_TABLE_DEPTH = 64;

    // Fixed-point constants
    localparam logic [63:0] ONE_Q48       = 64'd1 << 48;
    localparam logic [63:0] EXP_LIMIT_Q48 = 64'd50 << 48;
    localparam logic [63:0] LN2_Q32       = 64'hB17217F8;
    localparam logic [63:0] LOG2E_Q32     = 64'h171547653;
    localparam logic [63:0] ONES64        = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] POS_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MIN       = 64'h8000_0000_0000_0000;

    // Register indexes
    localparam logic [2:0] CFG_MODEL     = 3'd0;
    localparam logic [2:0] CFG_SHEAR     = 3'd1;
    localparam logic [2:0] CFG_POLY_GAIN = 3'd2;
    localparam logic [2:0] CFG_EXP_K1    = 3'd3;
    localparam logic [2:0] CFG_EXP_K2    = 3'd4;
    localparam logic [2:0] CFG_COS_SQ    = 3'd5;
    localparam logic [2:0] CFG_SIN_SQ    = 3'd6;

    // Model codes
    localparam logic [1:0] MODEL_ISO  = 2'd0;
    localparam logic [1:0] MODEL_POLY = 2'd1;
    localparam logic [1:0] MODEL_EXP  = 2'd2;

    // Register reset values
    localparam logic [31:0] RST_SHEAR     = 32'd5120000;
    localparam logic [31:0] RST_POLY_GAIN = 32'd1310720;
    localparam logic [31:0] RST_EXP_K1    = 32'd2560000;
    localparam logic [31:0] RST_EXP_K2    = 32'd983040;
    localparam logic [31:0] RST_COS_SQ    = 32'd976900000;
    localparam logic [31:0] RST_SIN_SQ    = 32'd1170583648;

    // Four 32x32 partial products of a 64x64 multiply
    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } pp_t;

    // Fields that ride along the fiber path
    typedef struct packed {
        logic [63:0] gc;
        logic [63:0] ga;
        logic [63:0] msc;
        logic [63:0] msa;
        logic [63:0] mg;
        logic [63:0] t;
        logic [63:0] dwp;
        logic [6:0]  n;
        logic        act;
        logic        poly;
        logic        bad;
    } side_t;

    // Positive stress parts waiting for the divider
    typedef struct packed {
        logic [63:0] pos_c;
        logic [63:0] pos_a;
        logic        bad;
    } dly_t;

    function automatic pp_t mul_pp(logic [63:0] a, logic [63:0] b);
        pp_t p;
        p.ll = 64'(a[31:0])  * 64'(b[31:0]);
        p.lh = 64'(a[31:0])  * 64'(b[63:32]);
        p.hl = 64'(a[63:32]) * 64'(b[31:0]);
        p.hh = 64'(a[63:32]) * 64'(b[63:32]);
        return p;
    endfunction

    function automatic logic [127:0] pp_sum(pp_t p);
        return 128'(p.ll) + (128'(p.lh) << 32) + (128'(p.hl) << 32) + (128'(p.hh) << 64);
    endfunction

    // Clip a wide magnitude to the 64-bit ceiling
    function automatic logic [63:0] sat64(logic [127:0] v);
        return (v[127:64] != '0) ? ONES64 : v[63:0];
    endfunction

    // Positive part minus inverse-square part, clamped; bit 64 is the clip flag
    function automatic logic [64:0] combine(logic [63:0] pos, logic [63:0] neg);
        logic [63:0] d;
        d = '0;
        if (pos == ONES64 || neg == ONES64)
            return {1'b1, (neg == ONES64) ? NEG_MIN : POS_MAX};
        if (pos >= neg)
        begin
            d = pos - neg;
            if (d > POS_MAX)
                return {1'b1, POS_MAX};
            return {1'b0, d};
        end
        d = neg - pos;
        if (d > NEG_MIN)
            return {1'b1, NEG_MIN};
        return {1'b0, (~d) + 64'd1};
    endfunction

    // 2^(i/D) in Q.52 by truncated series; arg_raw = floor(i*2^52/D)
    function automatic logic [63:0] pow2_entry(logic [63:0] arg_raw);
        logic [127:0] prod;
        logic [63:0]  arg;
        logic [63:0]  term;
        logic [63:0]  sum;
        prod = {64'b0, arg_raw} * {64'b0, LN2_Q32};
        arg  = prod[95:32];
        sum  = 64'd1 << 52;
        term = sum;
        for (int k = 1; k < 64; k++)
        begin
            if (term != '0)
            begin
                prod = {64'b0, term} * {64'b0, arg};
                term = prod[115:52] / 64'(k);
                sum  = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

// ----- rtl/core/hbs_div.sv -----
module hbs_div (
    input  logic         clk,
    input  logic         en,
    input  logic [31:0]  mu,
    input  logic [127:0] d2,
    output logic [63:0]  quo
);

    localparam int STEPS = 64;

    logic [127:0] rem_reg  [0:STEPS];
    logic [127:0] d2_reg   [0:STEPS];
    logic [63:0]  q_reg    [0:STEPS];
    logic         zero_reg [0:STEPS];
    logic         ovf_reg  [0:STEPS];
    logic [127:0] rem_next [0:STEPS-1];
    logic         take     [0:STEPS-1];
    logic [127:0] dividend;

    assign dividend = {40'b0, mu, 56'b0};

    // One restoring step per stage: shift, compare, subtract
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            take[k] = rem_reg[k][127] || ({rem_reg[k][126:0], 1'b0} >= d2_reg[k]);
            rem_next[k] = take[k] ? {rem_reg[k][126:0], 1'b0} - d2_reg[k]
                                  : {rem_reg[k][126:0], 1'b0};
        end
    end

    // Advance the divider stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= dividend;
            d2_reg[0]   <= d2;
            q_reg[0]    <= '0;
            zero_reg[0] <= (mu == '0);
            ovf_reg[0]  <= (mu != '0) && (dividend >= d2);
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                d2_reg[k+1]   <= d2_reg[k];
                q_reg[k+1]    <= {q_reg[k][62:0], take[k]};
                zero_reg[k+1] <= zero_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    assign quo = zero_reg[STEPS] ? '0 : (ovf_reg[STEPS] ? '1 : q_reg[STEPS]);

endmodule

// ----- rtl/core/hyperelastic_biaxial_stress.sv -----
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// input     | in        | in_valid/in_stall  | stretch_circ, stretch_axial
// output    | out       | out_valid/out_stall| stress_circ, stress_axial, saturated,
//           |           |                    | bad_stretch
// config    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle enters while the output is not stalled, and crosses 69
// register stages before its result is presented.
// Latency is set by the 64-stage restoring divider for the inverse-square term.
// Reset clears valid bits and loads register defaults; cfg_ready is always high.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module hyperelastic_biaxial_stress
    import hbs_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        stretch_circ,
    input  logic [31:0]        stretch_axial,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] stress_circ,
    output logic signed [63:0] stress_axial,
    output logic               saturated,
    output logic               bad_stretch,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int JW        = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int FDW       = 48 + JW;
    localparam int SIDE_LAST = 18;
    localparam int DLY       = 50;
    localparam int TOTAL     = 69;

    // Configuration registers
    logic [1:0]  model_reg;
    logic [31:0] mu_reg, gain_reg, k1_reg, k2_reg, cos_reg, sin_reg;

    logic             adv;
    logic [TOTAL-1:0] vld_reg;

    // Front stages
    logic [63:0]  sqc1_reg, sqa1_reg, p1_reg;
    pp_t          gc2_reg, ga2_reg, mc2_reg, ma2_reg, p22_reg;
    logic [63:0]  mg2_reg;
    logic         bad2_reg, bad3_reg;
    logic [63:0]  gc3_reg, ga3_reg, msc3_reg, msa3_reg, mg3_reg;
    logic [127:0] p23_reg;

    // Fiber path
    side_t        cr_reg [4:SIDE_LAST];
    logic [63:0]  e4_reg;
    pp_t          dp5_reg, ee5_reg, t5_reg;
    logic [63:0]  ee6_reg;
    pp_t          x7_reg;
    logic         eec7_reg;
    logic [63:0]  x8_reg;
    pp_t          y9_reg;
    logic [47:0]  f10_reg;
    logic [JW-1:0] j11_reg;
    logic [47:0]  r11_reg;
    logic [63:0]  a12_reg;
    pp_t          i12_reg;
    logic [63:0]  p2f13_reg;
    pp_t          q14_reg;
    logic [127:0] q15_reg;
    logic [63:0]  dwe16_reg;
    pp_t          fc17_reg, fa17_reg;
    logic         dwc17_reg;
    logic [63:0]  fc18_reg, fa18_reg;
    dly_t         dly_reg [0:DLY-1];

    // Output register
    logic [63:0]  out_c_reg, out_a_reg;
    logic         out_sat_reg, out_bad_reg;

    // Combinational helpers
    logic [63:0]  pow2_tab [0:EXP_TABLE_DEPTH];
    side_t        side_next [5:SIDE_LAST];
    logic [63:0]  i4_sum;
    logic [127:0] x_full, y_full, qsh_full;
    logic [199:0] q_shift;
    logic [FDW-1:0] fd;
    logic [JW-1:0] j_lo, j_hi;
    logic [63:0]  tab_lo, tab_hi, tab_diff;
    logic [63:0]  dw_sel, fc_next, fa_next;
    logic [64:0]  pos_c_sum, pos_a_sum;
    logic [63:0]  pos_c_next, pos_a_next, quo;
    logic [64:0]  cmb_c, cmb_a;

    // Build the 2^f table at elaboration
    for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++)
    begin : g_tab
        localparam logic [63:0] ARG = (64'(g) << 52) / EXP_TABLE_DEPTH;
        assign pow2_tab[g] = pow2_entry(ARG);
    end

    assign adv       = !(vld_reg[TOTAL-1] && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // Control: valid chain and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            model_reg <= MODEL_ISO;
            mu_reg    <= RST_SHEAR;
            gain_reg  <= RST_POLY_GAIN;
            k1_reg    <= RST_EXP_K1;
            k2_reg    <= RST_EXP_K2;
            cos_reg   <= RST_COS_SQ;
            sin_reg   <= RST_SIN_SQ;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MODEL:     model_reg <= cfg_data[1:0];
                    CFG_SHEAR:     mu_reg    <= cfg_data;
                    CFG_POLY_GAIN: gain_reg  <= cfg_data;
                    CFG_EXP_K1:    k1_reg    <= cfg_data;
                    CFG_EXP_K2:    k2_reg    <= cfg_data;
                    CFG_COS_SQ:    cos_reg   <= cfg_data;
                    CFG_SIN_SQ:    sin_reg   <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Datapath helpers between stages
    always_comb
    begin
        i4_sum   = gc3_reg + ga3_reg;
        x_full   = pp_sum(x7_reg) >> 16;
        y_full   = pp_sum(y9_reg) >> 32;
        // Side carry, with the fields filled in along the way
        for (int k = 5; k <= SIDE_LAST; k++)
            side_next[k] = cr_reg[k-1];
        side_next[6].dwp = sat64(pp_sum(dp5_reg) >> 48);
        side_next[6].t   = 64'(pp_sum(t5_reg) >> 40);
        side_next[10].n  = y_full[54:48];
        fd       = FDW'(f10_reg) * FDW'(EXP_TABLE_DEPTH);
        j_lo     = (fd[FDW-1:48] >= JW'(EXP_TABLE_DEPTH)) ? JW'(EXP_TABLE_DEPTH - 1)
                                                          : fd[FDW-1:48];
        j_hi     = j11_reg + JW'(1);
        tab_lo   = pow2_tab[j11_reg];
        tab_hi   = pow2_tab[j_hi];
        tab_diff = (tab_hi > tab_lo) ? tab_hi - tab_lo : '0;
        q_shift  = {72'b0, q15_reg} << cr_reg[15].n;
        qsh_full = q_shift[179:52];
        dw_sel   = cr_reg[16].poly ? cr_reg[16].dwp : dwe16_reg;
        // Fiber stress terms, zero unless a fiber model is selected and the fiber is stretched
        fc_next = '0;
        fa_next = '0;
        if (cr_reg[17].act)
        begin
            if (dwc17_reg)
            begin
                fc_next = (cr_reg[17].gc == '0) ? '0 : ONES64;
                fa_next = (cr_reg[17].ga == '0) ? '0 : ONES64;
            end
            else
            begin
                fc_next = sat64(pp_sum(fc17_reg) >> 47);
                fa_next = sat64(pp_sum(fa17_reg) >> 47);
            end
        end
        pos_c_sum  = {1'b0, cr_reg[18].msc} + {1'b0, fc18_reg};
        pos_a_sum  = {1'b0, cr_reg[18].msa} + {1'b0, fa18_reg};
        pos_c_next = (fc18_reg == ONES64 || pos_c_sum[64]) ? ONES64 : pos_c_sum[63:0];
        pos_a_next = (fa18_reg == ONES64 || pos_a_sum[64]) ? ONES64 : pos_a_sum[63:0];
        cmb_c = combine(dly_reg[DLY-1].pos_c, quo);
        cmb_a = combine(dly_reg[DLY-1].pos_a, quo);
    end

    // Advance the payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Squares and stretch product
            sqc1_reg <= 64'(stretch_circ) * 64'(stretch_circ);
            sqa1_reg <= 64'(stretch_axial) * 64'(stretch_axial);
            p1_reg   <= 64'(stretch_circ) * 64'(stretch_axial);
            // Partial products of invariant, matrix and P^2 terms
            gc2_reg  <= mul_pp(sqc1_reg, 64'(cos_reg));
            ga2_reg  <= mul_pp(sqa1_reg, 64'(sin_reg));
            mc2_reg  <= mul_pp(64'(mu_reg), sqc1_reg);
            ma2_reg  <= mul_pp(64'(mu_reg), sqa1_reg);
            p22_reg  <= mul_pp(p1_reg, p1_reg);
            mg2_reg  <= 64'(mu_reg) * 64'(gain_reg);
            bad2_reg <= (p1_reg == '0);
            // Sum partials
            gc3_reg  <= 64'(pp_sum(gc2_reg) >> 39);
            ga3_reg  <= 64'(pp_sum(ga2_reg) >> 39);
            msc3_reg <= 64'(pp_sum(mc2_reg) >> 48);
            msa3_reg <= 64'(pp_sum(ma2_reg) >> 48);
            p23_reg  <= pp_sum(p22_reg);
            mg3_reg  <= mg2_reg >> 8;
            bad3_reg <= bad2_reg;
            // Fiber invariant and side carry
            for (int k = 5; k <= SIDE_LAST; k++)
                cr_reg[k] <= side_next[k];
            e4_reg    <= i4_sum - ONE_Q48;
            cr_reg[4] <= '{gc: gc3_reg, ga: ga3_reg, msc: msc3_reg, msa: msa3_reg,
                           mg: mg3_reg, t: '0, dwp: '0, n: '0,
                           act: (model_reg == MODEL_POLY || model_reg == MODEL_EXP)
                                && (i4_sum > ONE_Q48),
                           poly: (model_reg == MODEL_POLY), bad: bad3_reg};
            dp5_reg <= mul_pp(cr_reg[4].mg, e4_reg);
            ee5_reg <= mul_pp(e4_reg, e4_reg);
            t5_reg  <= mul_pp(64'(k1_reg), e4_reg);
            ee6_reg <= sat64(pp_sum(ee5_reg) >> 48);
            // Exponent argument, capped at 50
            x7_reg   <= mul_pp(64'(k2_reg), ee6_reg);
            eec7_reg <= (ee6_reg == ONES64) && (k2_reg != '0);
            x8_reg   <= (eec7_reg || x_full > 128'(EXP_LIMIT_Q48)) ? EXP_LIMIT_Q48
                                                                   : x_full[63:0];
            y9_reg   <= mul_pp(x8_reg, LOG2E_Q32);
            f10_reg  <= y_full[47:0];
            // Table interpolation of 2^f
            j11_reg  <= j_lo;
            r11_reg  <= fd[47:0];
            a12_reg  <= tab_lo;
            i12_reg  <= mul_pp(tab_diff, 64'(r11_reg));
            p2f13_reg <= a12_reg + 64'(pp_sum(i12_reg) >> 48);
            q14_reg  <= mul_pp(cr_reg[13].t, p2f13_reg);
            q15_reg  <= pp_sum(q14_reg);
            dwe16_reg <= sat64(qsh_full) | ((q_shift[199:180] != '0) ? ONES64 : '0);
            // Fiber stress products
            fc17_reg  <= mul_pp(dw_sel, cr_reg[16].gc);
            fa17_reg  <= mul_pp(dw_sel, cr_reg[16].ga);
            dwc17_reg <= (dw_sel == ONES64);
            fc18_reg  <= fc_next;
            fa18_reg  <= fa_next;
            // Hold positive parts until the divider catches up
            dly_reg[0] <= '{pos_c: pos_c_next, pos_a: pos_a_next, bad: cr_reg[18].bad};
            for (int k = 1; k < DLY; k++)
                dly_reg[k] <= dly_reg[k-1];
            // Final combine
            out_bad_reg <= dly_reg[DLY-1].bad;
            out_c_reg   <= dly_reg[DLY-1].bad ? '0 : cmb_c[63:0];
            out_a_reg   <= dly_reg[DLY-1].bad ? '0 : cmb_a[63:0];
            out_sat_reg <= !dly_reg[DLY-1].bad && (cmb_c[64] || cmb_a[64]);
        end
    end

    hbs_div u_div (
        .clk (clk),
        .en  (adv),
        .mu  (mu_reg),
        .d2  (p23_reg),
        .quo (quo)
    );

    assign out_valid    = vld_reg[TOTAL-1];
    assign stress_circ  = out_c_reg;
    assign stress_axial = out_a_reg;
    assign saturated    = out_sat_reg;
    assign bad_stretch  = out_bad_reg;

    // A zero stretch product yields zero stresses and no clip flag
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_stretch) |-> (stress_circ == '0 && stress_axial == '0 && !saturated))
        else $error("bad stretch result not zero");

    // An accepted request enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted request lost");

    // Input stalls only behind a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

endmodule

// ----- verif/hyperelastic_biaxial_stress_tb.sv -----
module hyperelastic_biaxial_stress_tb;
    import hbs_pkg::*;

    localparam int TAB_DEPTH = DEF_EXP_TABLE_DEPTH;
    localparam int PIPE_LAT = 69;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [63:0] circ;
        logic signed [63:0] axial;
        logic sat;
        logic bad;
    } stress_t;

    typedef struct {
        logic [31:0] lc;
        logic [31:0] la;
        logic        known;
        stress_t     res;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [31:0] stretch_circ;
    logic [31:0] stretch_axial;
    logic out_valid;
    logic out_stall;
    logic signed [63:0] stress_circ;
    logic signed [63:0] stress_axial;
    logic saturated;
    logic bad_stretch;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    // material settings mirrored from the register writes
    logic [1:0]  mdl;
    logic [31:0] mu;
    logic [31:0] gain;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] cos_sq;
    logic [31:0] sin_sq;
    logic [63:0] pow2_lut [0:TAB_DEPTH];

    stress_t pending_stress [$];
    int errors;
    int n_checked;
    int n_sat;
    int n_bad;
    bit hold_out;

    hyperelastic_biaxial_stress dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("Test completed with failures");
        $finish;
    end

    // saturating product shifted right
    function automatic logic [63:0] smul(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        if (a == 0 || b == 0)
            return 64'd0;
        if (a == ALL_ONES || b == ALL_ONES)
            return ALL_ONES;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p[127:64] != 0) ? ALL_ONES : p[63:0];
    endfunction

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (a == ALL_ONES || b == ALL_ONES || s[64])
            return ALL_ONES;
        return s[63:0];
    endfunction

    function automatic logic [63:0] sub_clamp(logic [63:0] pos, logic [63:0] neg,
                                              inout logic flag);
        logic [63:0] d;
        if (pos == ALL_ONES || neg == ALL_ONES)
        begin
            flag = 1'b1;
            return (neg == ALL_ONES) ? NEG_MIN : POS_MAX;
        end
        if (pos >= neg)
        begin
            d = pos - neg;
            if (d > POS_MAX)
            begin
                flag = 1'b1;
                return POS_MAX;
            end
            return d;
        end
        d = neg - pos;
        if (d > NEG_MIN)
        begin
            flag = 1'b1;
            return NEG_MIN;
        end
        return ~d + 64'd1;
    endfunction

    task automatic build_lut();
        logic [127:0] w;
        logic [63:0] arg;
        logic [63:0] term;
        logic [63:0] acc;
        for (int i = 0; i <= TAB_DEPTH; i++)
        begin
            arg = (64'(i) << 52) / 64'(TAB_DEPTH);
            w = {64'd0, arg} * 128'h0B17217F8;
            arg = w[95:32];
            acc = 64'd1 << 52;
            term = acc;
            for (int k = 1; k < 64 && term != 0; k++)
            begin
                w = {64'd0, term} * {64'd0, arg};
                term = w[115:52] / 64'(k);
                acc = acc + term;
            end
            pow2_lut[i] = acc;
        end
    endtask

    function automatic logic [63:0] exp_dw(logic [63:0] e);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] f;
        logic [63:0] fd;
        logic [63:0] j;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] b;
        logic [127:0] w;
        logic [127:0] q;
        int n;
        x = smul({32'd0, k2}, smul(e, e, 48), 16);
        if (x > EXP_LIMIT_Q48)
            x = EXP_LIMIT_Q48;
        w = {64'd0, x} * {64'd0, LOG2E_Q32};
        y = w[95:32];
        n = int'(y >> 48);
        t = smul({32'd0, k1}, e, 40);
        if (t == 0 || t == ALL_ONES)
            return t;
        f = y & (ONE_Q48 - 1);
        fd = f * 64'(TAB_DEPTH);
        j = fd >> 48;
        r = fd & (ONE_Q48 - 1);
        if (j >= TAB_DEPTH)
            j = TAB_DEPTH - 1;
        a = pow2_lut[j];
        b = pow2_lut[j + 1];
        if (b > a)
        begin
            w = {64'd0, b - a} * {64'd0, r};
            a = a + w[111:48];
        end
        q = {64'd0, t} * {64'd0, a};
        if (n <= 52)
        begin
            q = q >> (52 - n);
            return (q[127:64] != 0) ? ALL_ONES : q[63:0];
        end
        n = n - 52;
        if (q[127:64] != 0 || (q[63:0] >> (64 - n)) != 0)
            return ALL_ONES;
        return q[63:0] << n;
    endfunction

    // mu * 2^120 / P^2, saturating
    function automatic logic [63:0] inv_sq(logic [63:0] p);
        logic [255:0] num;
        logic [255:0] den;
        logic [255:0] q;
        if (mu == 0)
            return 64'd0;
        num = 256'(mu) << 120;
        den = 256'(p) * 256'(p);
        q = num / den;
        return (q[255:64] != 0) ? ALL_ONES : q[63:0];
    endfunction

    function automatic stress_t wall_stress(logic [31:0] lc, logic [31:0] la);
        stress_t s;
        logic [63:0] p;
        logic [63:0] sqc;
        logic [63:0] sqa;
        logic [63:0] gc;
        logic [63:0] ga;
        logic [63:0] i4;
        logic [63:0] fc;
        logic [63:0] fa;
        logic [63:0] dw;
        logic [63:0] e;
        logic [127:0] w;
        logic flag;
        p = 64'(lc) * 64'(la);
        s.bad = 1'b0;
        if (p == 0)
        begin
            s.circ = 0;
            s.axial = 0;
            s.sat = 1'b0;
            s.bad = 1'b1;
            return s;
        end
        sqc = 64'(lc) * 64'(lc);
        sqa = 64'(la) * 64'(la);
        w = {64'd0, sqc} * {96'd0, cos_sq};
        gc = w[102:39];
        w = {64'd0, sqa} * {96'd0, sin_sq};
        ga = w[102:39];
        i4 = gc + ga;
        fc = 0;
        fa = 0;
        if ((mdl == MODEL_POLY || mdl == MODEL_EXP) && i4 > ONE_Q48)
        begin
            e = i4 - ONE_Q48;
            if (mdl == MODEL_POLY)
                dw = smul(smul({32'd0, mu}, {32'd0, gain}, 8), e, 48);
            else
                dw = exp_dw(e);
            fc = smul(dw, gc, 47);
            fa = smul(dw, ga, 47);
        end
        flag = 1'b0;
        s.circ = sub_clamp(sadd(smul({32'd0, mu}, sqc, 48), fc), inv_sq(p), flag);
        s.axial = sub_clamp(sadd(smul({32'd0, mu}, sqa, 48), fa), inv_sq(p), flag);
        s.sat = flag;
        return s;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODEL:     mdl = val[1:0];
            CFG_SHEAR:     mu = val;
            CFG_POLY_GAIN: gain = val;
            CFG_EXP_K1:    k1 = val;
            CFG_EXP_K2:    k2 = val;
            CFG_COS_SQ:    cos_sq = val;
            CFG_SIN_SQ:    sin_sq = val;
            default: ;
        endcase
    endtask

    // send one request, queue its expected stresses
    task automatic send(logic [31:0] lc, logic [31:0] la);
        stretch_circ <= lc;
        stretch_axial <= la;
        in_valid <= 1'b1;
        pending_stress.push_back(wall_stress(lc, la));
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_stress.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_stretch();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(64'($urandom_range(0, 32'h3FFF_FFFF)) + 32'h0800_0000);
            2: return $urandom_range(1, 255);
            default: return $urandom_range(32'h0C00_0000, 32'h2000_0000);
        endcase
    endfunction

    task automatic random_burst(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                send(rand_stretch(), rand_stretch());
                left--;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // receiver stall pattern, plus a long hold when asked
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_out)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 9) < 3)
                out_stall <= ($urandom_range(0, 1) == 1);
            else
                out_stall <= 1'b0;
        end
    end

    // compare each result against the oldest expectation
    always @(posedge clk)
    begin
        stress_t exp_s;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_stress.size() == 0)
            begin
                $display("%0t: unexpected result circ=%h axial=%h", $time,
                         stress_circ, stress_axial);
                errors++;
            end
            else
            begin
                exp_s = pending_stress.pop_front();
                n_checked++;
                if (exp_s.sat) n_sat++;
                if (exp_s.bad) n_bad++;
                if (stress_circ !== exp_s.circ)
                begin
                    $display("%0t: stress_circ expected %h actual %h", $time,
                             exp_s.circ, stress_circ);
                    errors++;
                end
                if (stress_axial !== exp_s.axial)
                begin
                    $display("%0t: stress_axial expected %h actual %h", $time,
                             exp_s.axial, stress_axial);
                    errors++;
                end
                if (saturated !== exp_s.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_s.sat, saturated);
                    errors++;
                end
                if (bad_stretch !== exp_s.bad)
                begin
                    $display("%0t: bad_stretch expected %b actual %b", $time,
                             exp_s.bad, bad_stretch);
                    errors++;
                end
            end
        end
    end

    row_t plan [$];
    row_t row;
    stress_t got;
    logic [31:0] one_q28;

    initial
    begin
        errors = 0;
        n_checked = 0;
        n_sat = 0;
        n_bad = 0;
        hold_out = 1'b0;
        one_q28 = 32'h1000_0000;
        rst_n = 1'b0;
        in_valid = 1'b0;
        stretch_circ = '0;
        stretch_axial = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mdl = MODEL_ISO;
        mu = RST_SHEAR;
        gain = RST_POLY_GAIN;
        k1 = RST_EXP_K1;
        k2 = RST_EXP_K2;
        cos_sq = RST_COS_SQ;
        sin_sq = RST_SIN_SQ;
        build_lut();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at reset settings; zero-stretch rows have a known answer
        got.circ = 0;
        got.axial = 0;
        got.sat = 0;
        got.bad = 1;
        plan.push_back('{32'd0, 32'd0, 1'b1, got});
        plan.push_back('{32'd0, 32'hFFFF_FFFF, 1'b1, got});
        plan.push_back('{32'hFFFF_FFFF, 32'd0, 1'b1, got});
        got.bad = 0;
        got.sat = 1;
        got.circ = NEG_MIN;
        got.axial = NEG_MIN;
        // tiny stretches: inverse-square term overflows
        plan.push_back('{32'd1, 32'd1, 1'b1, got});
        plan.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, got});
        plan.push_back('{one_q28, one_q28, 1'b0, got});
        plan.push_back('{32'h1800_0000, 32'h1400_0000, 1'b0, got});
        plan.push_back('{32'h0800_0000, 32'h2000_0000, 1'b0, got});
        plan.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, got});
        plan.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, got});
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.known)
            begin
                got = wall_stress(row.lc, row.la);
                if (got.circ !== row.res.circ || got.axial !== row.res.axial ||
                    got.sat !== row.res.sat || got.bad !== row.res.bad)
                begin
                    $display("%0t: directed row %0d expected %h %h %b %b actual %h %h %b %b",
                             $time, i, row.res.circ, row.res.axial, row.res.sat,
                             row.res.bad, got.circ, got.axial, got.sat, got.bad);
                    errors++;
                end
            end
            send(row.lc, row.la);
        end
        drain();

        // walk every model, including the unused code and extreme settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_MODEL, (ph == 3) ? 32'd3 : 32'(ph % 3));
            write_reg(CFG_SHEAR, (ph == 4) ? 32'hFFFF_FFFF : (ph == 5) ? 32'd0 : $urandom);
            write_reg(CFG_POLY_GAIN, (ph == 6) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0010_0000));
            write_reg(CFG_EXP_K1, (ph == 7) ? 32'hFFFF_FFFF : (ph == 2) ? 32'd0 : $urandom);
            write_reg(CFG_EXP_K2, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0020_0000));
            write_reg(CFG_COS_SQ, (ph == 6) ? 32'h8000_0000 : (ph == 1) ? 32'd0
                                  : $urandom_range(0, 32'h8000_0000));
            write_reg(CFG_SIN_SQ, (ph == 7) ? 32'h8000_0000 : (ph == 4) ? 32'd0
                                  : $urandom_range(0, 32'h8000_0000));
            send(one_q28, one_q28);
            send(32'hFFFF_FFFF, 32'h0000_0001);
            random_burst(110);
            if (ph == 2)
            begin
                // hold the receiver so the pipeline backs up into the input
                hold_out = 1'b1;
                fork
                    random_burst(150);
                    begin
                        repeat (300) @(posedge clk);
                        hold_out = 1'b0;
                    end
                join
            end
            drain();
        end

        in_valid <= 1'b0;
        repeat (PIPE_LAT + 10) @(posedge clk);
        $display("Covered %0d results (%0d saturated, %0d bad stretch) over all models",
                 n_checked, n_sat, n_bad);
        if (errors == 0 && pending_stress.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/hbs_pkg.sv
rtl/core/hbs_div.sv
rtl/core/hyperelastic_biaxial_stress.sv
verif/hyperelastic_biaxial_stress_tb.sv
